// ----- rtl/core/msseq_pkg.sv -----
package msseq_pkg;

  // Table geometry
  localparam int MAX_STEPS = 256;
  localparam int SLOT_W    = $clog2(MAX_STEPS);

  // Item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  // Step kinds
  localparam logic [1:0] KIND_MOVE  = 2'd0;
  localparam logic [1:0] KIND_PIN   = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;
  localparam logic [1:0] KIND_UNTIL = 2'd3;

  // Wait phases, reported on the phase output
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MOVE  = 2'd1;
  localparam logic [1:0] PH_DELAY = 2'd2;
  localparam logic [1:0] PH_UNTIL = 2'd3;

  // One table entry: kind over payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] payload;
  } step_entry_t;

  // One result transaction
  typedef struct packed {
    logic              move_valid;
    logic signed [15:0] move_x;
    logic signed [15:0] move_y;
    logic              pin_valid;
    logic [2:0]        pin_port;
    logic [3:0]        pin_number;
    logic              pin_level;
    logic              running;
    logic              aborted;
    logic              finished;
    logic [7:0]        current_step;
    logic [1:0]        phase;
  } result_t;

endpackage

// ----- rtl/core/msseq_step_ram.sv -----
module msseq_step_ram (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [msseq_pkg::SLOT_W-1:0]        wr_addr,
  input  msseq_pkg::step_entry_t              wr_data,
  input  logic [msseq_pkg::SLOT_W-1:0]        rd_addr,
  output msseq_pkg::step_entry_t              rd_data
);
  import msseq_pkg::*;

  step_entry_t mem [MAX_STEPS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/core/msseq_out_skid.sv -----
module msseq_out_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  msseq_pkg::result_t  push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output msseq_pkg::result_t  out_data
);
  import msseq_pkg::*;

  logic    main_v;
  result_t main_d;
  logic    skid_v;
  result_t skid_d;
  logic    drain;

  assign drain     = main_v & ~out_stall;
  assign full      = skid_v;
  assign out_valid = main_v;
  assign out_data  = main_d;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (skid_v) begin
      if (drain) begin
        main_d <= skid_d;
        skid_v <= 1'b0;
      end
    end else if (push) begin
      if (!main_v || drain) begin
        main_v <= 1'b1;
        main_d <= push_data;
      end else begin
        skid_v <= 1'b1;
        skid_d <= push_data;
      end
    end else if (drain) begin
      main_v <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/motion_step_sequencer_unit.sv -----
// Accepted results go to the output register, or to the skid entry while it is stalled.
// One transaction per cycle unless in_stall; the step table read for the next tick is
// issued in the same cycle the step index is updated, so ticks follow back to back.
// Reset (rst, synchronous): run stopped, index, limit, phase, delay stamp and
// wait_target cleared, result buffer empty; step table contents undefined until written.
module motion_step_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [7:0]         step_slot,
  input  logic [1:0]         step_kind,
  input  logic [31:0]        step_payload,
  input  logic [7:0]         step_total,
  input  logic [31:0]        now_ms,
  input  logic               move_accept,
  input  logic               motion_busy,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               move_valid,
  output logic signed [15:0] move_x,
  output logic signed [15:0] move_y,
  output logic               pin_valid,
  output logic [2:0]         pin_port,
  output logic [3:0]         pin_number,
  output logic               pin_level,
  output logic               running,
  output logic               aborted,
  output logic               finished,
  output logic [7:0]         current_step,
  output logic [1:0]         phase
);
  import msseq_pkg::*;

  // sequencer state
  logic [31:0]       wait_target;
  logic [SLOT_W-1:0] step_limit, step_limit_next;
  logic [SLOT_W-1:0] step_pointer, step_pointer_next;
  logic [1:0]        wait_phase, wait_phase_next;
  logic [31:0]       delay_start, delay_start_next;
  logic              active, active_next;

  // table access
  logic              wr_en;
  step_entry_t       wr_data;
  step_entry_t       rd_data;
  logic              fwd_hit;
  step_entry_t       fwd_data;
  step_entry_t       entry;

  logic              accept;
  result_t           res;
  result_t           out_data;
  logic [31:0]       elapsed;
  logic [31:0]       until_diff;

  assign accept  = in_valid & ~in_stall;
  assign wr_data = '{kind: step_kind, payload: step_payload};

  msseq_step_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (step_slot),
    .wr_data (wr_data),
    .rd_addr (step_pointer_next),
    .rd_data (rd_data)
  );

  // current entry: memory data, or the write that landed while it was read
  always_comb begin
    entry = fwd_hit ? fwd_data : rd_data;
    if (int'(step_pointer) >= MAX_STEPS) begin
      entry = '0;
    end
  end

  assign elapsed    = now_ms - delay_start;
  assign until_diff = now_ms - wait_target;

  // per-transaction step logic
  always_comb begin
    step_limit_next   = step_limit;
    step_pointer_next = step_pointer;
    wait_phase_next   = wait_phase;
    delay_start_next  = delay_start;
    active_next       = active;
    wr_en             = 1'b0;
    res               = '0;
    if (accept) begin
      case (op)
        OP_WRITE: begin
          wr_en = int'(step_slot) < MAX_STEPS;
        end
        OP_START: begin
          step_limit_next   = step_total;
          step_pointer_next = '0;
          wait_phase_next   = PH_IDLE;
          active_next       = step_total != 8'd0;
        end
        OP_TICK: begin
          if (active) begin
            if (step_pointer >= step_limit) begin
              active_next  = 1'b0;
              res.finished = 1'b1;
            end else begin
              case (wait_phase)
                PH_IDLE: begin
                  case (entry.kind)
                    KIND_MOVE: begin
                      res.move_valid = 1'b1;
                      res.move_x     = entry.payload[15:0];
                      res.move_y     = entry.payload[31:16];
                      if (move_accept) begin
                        wait_phase_next = PH_MOVE;
                      end else begin
                        active_next = 1'b0;
                        res.aborted = 1'b1;
                      end
                    end
                    KIND_PIN: begin
                      res.pin_valid     = 1'b1;
                      res.pin_port      = entry.payload[2:0];
                      res.pin_number    = entry.payload[6:3];
                      res.pin_level     = entry.payload[7];
                      step_pointer_next = step_pointer + 1'b1;
                    end
                    KIND_DELAY: begin
                      delay_start_next = now_ms;
                      wait_phase_next  = PH_DELAY;
                    end
                    default: begin
                      wait_phase_next = PH_UNTIL;
                    end
                  endcase
                end
                PH_MOVE: begin
                  if (!motion_busy) begin
                    step_pointer_next = step_pointer + 1'b1;
                    wait_phase_next   = PH_IDLE;
                  end
                end
                PH_DELAY: begin
                  if (elapsed >= entry.payload) begin
                    step_pointer_next = step_pointer + 1'b1;
                    wait_phase_next   = PH_IDLE;
                  end
                end
                default: begin
                  if (!until_diff[31]) begin
                    step_pointer_next = step_pointer + 1'b1;
                    wait_phase_next   = PH_IDLE;
                  end
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.running      = active_next;
    res.current_step = step_pointer_next;
    res.phase        = wait_phase_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_target  <= '0;
      step_limit   <= '0;
      step_pointer <= '0;
      wait_phase   <= PH_IDLE;
      delay_start  <= '0;
      active       <= 1'b0;
      fwd_hit      <= 1'b0;
    end else begin
      if (cfg_write) begin
        wait_target <= cfg_data;
      end
      step_limit   <= step_limit_next;
      step_pointer <= step_pointer_next;
      wait_phase   <= wait_phase_next;
      delay_start  <= delay_start_next;
      active       <= active_next;
      fwd_hit      <= wr_en && (step_slot == step_pointer_next);
    end
  end

  // forwarded write data
  always_ff @(posedge clk) begin
    fwd_data <= wr_data;
  end

  msseq_out_skid u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign move_valid   = out_data.move_valid;
  assign move_x       = out_data.move_x;
  assign move_y       = out_data.move_y;
  assign pin_valid    = out_data.pin_valid;
  assign pin_port     = out_data.pin_port;
  assign pin_number   = out_data.pin_number;
  assign pin_level    = out_data.pin_level;
  assign running      = out_data.running;
  assign aborted      = out_data.aborted;
  assign finished     = out_data.finished;
  assign current_step = out_data.current_step;
  assign phase        = out_data.phase;

endmodule
